### src/obdq_pkg.sv
// Shared types, constants and helpers for the ordered Bayer dither quantizer.
`default_nettype none

package obdq_pkg;

   localparam int unsigned GRAY_W    = 8;
   localparam int unsigned COORD_W   = 12;
   localparam int unsigned LEVEL_W   = 8;
   localparam int unsigned SIZE_W    = 3;
   localparam int unsigned LEVELS_W  = 4;
   localparam int unsigned TAP_W     = 4;   // largest matrix is 16 x 16
   localparam int unsigned THRESH_W  = 8;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [SIZE_W-1:0]   SIZE_MAX     = 3'd4;
   localparam logic [LEVELS_W-1:0] LEVELS_MIN   = 4'd1;
   localparam logic [LEVELS_W-1:0] LEVELS_MAX   = 4'd8;
   localparam logic [SIZE_W-1:0]   SIZE_RESET   = 3'd2;
   localparam logic [LEVELS_W-1:0] LEVELS_RESET = 4'd1;
   localparam logic [THRESH_W-1:0] THRESH_MID   = 8'd128;

   // Register index, taken from paddr[2]
   typedef enum logic {
      REG_DITHER_SIZE = 1'b0,
      REG_LEVELS      = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [SIZE_W-1:0]   dither_size_log2;
      logic [LEVELS_W-1:0] levels_log2;
   } cfg_type;

   // Largest level index for a saturated bit count
   function automatic logic [LEVEL_W-1:0] max_level(input logic [LEVELS_W-1:0] bits);
      logic [LEVEL_W:0] full;
      full = (9'd1 << bits) - 9'd1;
      return full[LEVEL_W-1:0];
   endfunction

   function automatic logic [LEVELS_W-1:0] sat_levels(input logic [LEVELS_W-1:0] raw);
      logic [LEVELS_W-1:0] b;
      b = raw;
      if (b < LEVELS_MIN) b = LEVELS_MIN;
      if (b > LEVELS_MAX) b = LEVELS_MAX;
      return b;
   endfunction

endpackage

`default_nettype wire

### src/obdq_csr.sv
// Configuration registers behind the APB-style port.
`default_nettype none

module obdq_csr
   import obdq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign idx   = reg_index_type'(csr_paddr[2]);
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_DITHER_SIZE: cfg_in.dither_size_log2 = csr_pwdata[SIZE_W-1:0];
            REG_LEVELS:      cfg_in.levels_log2      = csr_pwdata[LEVELS_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_DITHER_SIZE: csr_prdata = CSR_DATA_W'(cfg_ff.dither_size_log2);
         REG_LEVELS:      csr_prdata = CSR_DATA_W'(cfg_ff.levels_log2);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dither_size_log2 <= SIZE_RESET;
         cfg_ff.levels_log2      <= LEVELS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### src/obdq_threshold.sv
// Bayer threshold from the low coordinate bits: interleave, then bit reverse.
`default_nettype none

module obdq_threshold
   import obdq_pkg::*;
(
   input  wire logic [TAP_W-1:0]    x,
   input  wire logic [TAP_W-1:0]    y,
   input  wire logic [SIZE_W-1:0]   size_log2,
   output logic      [THRESH_W-1:0] thresh
);

   logic [SIZE_W-1:0]   s;
   logic [TAP_W-1:0]    mask;
   logic [TAP_W-1:0]    xm, ym, a;
   logic [THRESH_W-1:0] n;

   always_comb begin
      s    = (size_log2 > SIZE_MAX) ? SIZE_MAX : size_log2;
      mask = TAP_W'((5'd1 << s) - 5'd1);
      xm   = x & mask;
      ym   = y & mask;
      a    = xm ^ ym;
      for (int i = 0; i < TAP_W; i++) begin
         n[2*i]   = a[i];
         n[2*i+1] = ym[i];
      end
      for (int j = 0; j < THRESH_W; j++) begin
         thresh[THRESH_W-1-j] = n[j];
      end
      // a single-entry matrix sits at mid-scale
      if (s == '0) thresh = THRESH_MID;
   end

endmodule

`default_nettype wire

### src/obdq_quant.sv
// Scale, offset by the centered threshold, bin and clamp one sample.
`default_nettype none

module obdq_quant
   import obdq_pkg::*;
(
   input  wire logic [GRAY_W-1:0]   gray,
   input  wire logic [THRESH_W-1:0] thresh,
   input  wire logic [LEVELS_W-1:0] levels_log2,
   output logic      [LEVEL_W-1:0]  level
);

   localparam int unsigned SUM_W = 18;

   logic [LEVELS_W-1:0]     b;
   logic [15:0]             scaled;
   logic signed [SUM_W-1:0] v, vm1;
   logic [LEVEL_W-1:0]      bin, top;

   always_comb begin
      b      = sat_levels(levels_log2);
      scaled = 16'(gray) << b;
      v      = $signed({2'b00, scaled}) + $signed({10'b0, thresh})
               - $signed(SUM_W'(THRESH_MID));
      vm1    = v - 18'sd1;
      // bins are inclusive at the top, hence the minus one
      bin    = vm1[15:8];
      top    = max_level(b);
      if (v[SUM_W-1] || v == '0) level = '0;
      else if (bin > top)        level = top;
      else                       level = bin;
   end

endmodule

`default_nettype wire

### src/ordered_bayer_dither_quantizer.sv
// Ordered Bayer dither quantizer top level: handshake pipeline and config port.
//
// One gray pixel enters on the req_ channel with its column and row; one
// quantized level leaves on the rsp_ channel per pixel, in order.
// Both channels are valid/ready; an item moves when valid and ready are high.
// rsp_valid rises once an accepted pixel has passed the input register
// and then, through the threshold/add/clamp logic, the result register.
// Throughput is one item per clock while rsp_ready is high, since every
// stage can load while the result register is being taken.
// When rsp_ready is low the result holds, the input register fills, and
// req_ready falls only once both stages are occupied.
// The csr_ port holds dither_size_log2 (address 0) and levels_log2
// (address 4); write them only while no item is in flight.
// Synchronous reset empties both stages and restores size 2 and 1 bit.
`default_nettype none

module ordered_bayer_dither_quantizer
   import obdq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [GRAY_W-1:0]     req_gray_in,
   input  wire logic [COORD_W-1:0]    req_column,
   input  wire logic [COORD_W-1:0]    req_row,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [LEVEL_W-1:0]    rsp_level,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type cfg;

   logic               s1_valid_ff, s1_valid_in;
   logic [GRAY_W-1:0]  s1_gray_ff;
   logic [TAP_W-1:0]   s1_x_ff, s1_y_ff;
   logic               out_valid_ff, out_valid_in;
   logic [LEVEL_W-1:0] out_level_ff, level_in;
   logic [THRESH_W-1:0] thresh;
   logic               out_load, req_take;

   obdq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   obdq_threshold u_thresh (
      .x         (s1_x_ff),
      .y         (s1_y_ff),
      .size_log2 (cfg.dither_size_log2),
      .thresh    (thresh)
   );

   obdq_quant u_quant (
      .gray        (s1_gray_ff),
      .thresh      (thresh),
      .levels_log2 (cfg.levels_log2),
      .level       (level_in)
   );

   // result register can load when empty or being taken
   assign out_load  = !out_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_load;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      s1_valid_in  = req_take ? 1'b1 : (out_load ? 1'b0 : s1_valid_ff);
      out_valid_in = out_load ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_gray_ff <= req_gray_in;
         s1_x_ff    <= req_column[TAP_W-1:0];
         s1_y_ff    <= req_row[TAP_W-1:0];
      end
      if (out_load && s1_valid_ff) begin
         out_level_ff <= level_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_level = out_level_ff;

   // input stalls only with both stages full and the result blocked
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && out_valid_ff && !rsp_ready))
      else $error("req_ready low while pipeline has room");

   // a waiting item is never dropped while the output is blocked
   a_no_item_lost: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_ready) |=> s1_valid_ff)
      else $error("stage-one item lost during stall");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !out_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

### tb/sv/dither_level_checker.sv
// Dither quantizer checker: tracks config writes, checks reads, predicts, compares levels.
`default_nettype none

module dither_level_checker
   import obdq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [GRAY_W-1:0]     req_gray_in,
   input  wire logic [COORD_W-1:0]    req_column,
   input  wire logic [COORD_W-1:0]    req_row,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [LEVEL_W-1:0]    rsp_level,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic [CSR_DATA_W-1:0] csr_prdata,
   input  wire logic                  csr_pready,
   output int unsigned                fail_count,
   output int unsigned                levels_pending
);

   cfg_type              cfg;
   logic [LEVEL_W-1:0]   level_queue [$];
   logic [LEVEL_W-1:0]   want_level;
   logic [CSR_DATA_W-1:0] want_data;
   reg_index_type        csr_index;

   initial begin
      fail_count     = 0;
      levels_pending = 0;
   end

   // Bit-reversed interleave of (x^y, y) over the low size bits of the position
   function automatic logic [THRESH_W-1:0] matrix_threshold(
      input logic [COORD_W-1:0] col,
      input logic [COORD_W-1:0] row,
      input logic [SIZE_W-1:0]  size
   );
      logic [TAP_W-1:0]    mask;
      logic [TAP_W-1:0]    xs;
      logic [TAP_W-1:0]    ys;
      logic [TAP_W-1:0]    diag;
      logic [THRESH_W-1:0] woven;
      logic [THRESH_W-1:0] thresh;
      if (size == 0) return THRESH_MID;
      mask = TAP_W'((5'd1 << size) - 5'd1);
      xs   = col[TAP_W-1:0] & mask;
      ys   = row[TAP_W-1:0] & mask;
      diag = xs ^ ys;
      for (int i = 0; i < TAP_W; i++) begin
         woven[2*i]   = diag[i];
         woven[2*i+1] = ys[i];
      end
      for (int j = 0; j < THRESH_W; j++) thresh[THRESH_W-1-j] = woven[j];
      return thresh;
   endfunction

   function automatic logic [LEVEL_W-1:0] dithered_level(
      input logic [GRAY_W-1:0]  gray,
      input logic [COORD_W-1:0] col,
      input logic [COORD_W-1:0] row,
      input cfg_type            c
   );
      logic [SIZE_W-1:0]   size;
      logic [LEVELS_W-1:0] bits;
      int                  sum;
      int                  lev;
      int                  top;
      size = (c.dither_size_log2 > SIZE_MAX) ? SIZE_MAX : c.dither_size_log2;
      bits = c.levels_log2;
      if (bits < LEVELS_MIN) bits = LEVELS_MIN;
      if (bits > LEVELS_MAX) bits = LEVELS_MAX;
      sum = (int'(gray) << bits) + int'(matrix_threshold(col, row, size)) - 128;
      top = (1 << bits) - 1;
      // bins are closed at the top, so an exact multiple of 256 falls one lower
      lev = (sum <= 0) ? 0 : ((sum - 1) >> 8);
      if (lev > top) lev = top;
      return LEVEL_W'(lev);
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.dither_size_log2 = SIZE_RESET;
         cfg.levels_log2      = LEVELS_RESET;
         level_queue.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            csr_index = reg_index_type'(csr_paddr[2]);
            if (csr_pwrite) begin
               if (csr_index == REG_DITHER_SIZE)
                  cfg.dither_size_log2 = csr_pwdata[SIZE_W-1:0];
               else
                  cfg.levels_log2 = csr_pwdata[LEVELS_W-1:0];
            end else begin
               want_data = (csr_index == REG_DITHER_SIZE) ? CSR_DATA_W'(cfg.dither_size_log2)
                                                          : CSR_DATA_W'(cfg.levels_log2);
               if (csr_prdata !== want_data)
                  note_failure($sformatf("csr read mismatch at %0d: expected %0h got %0h",
                                         csr_paddr, want_data, csr_prdata));
            end
         end
         if (req_valid && req_ready)
            level_queue.push_back(dithered_level(req_gray_in, req_column, req_row, cfg));
         if (rsp_valid && rsp_ready) begin
            if (level_queue.size() == 0) begin
               note_failure($sformatf("level %0d with no pixel pending", rsp_level));
            end else begin
               want_level = level_queue.pop_front();
               if (rsp_level !== want_level)
                  note_failure($sformatf("level mismatch: expected %0d got %0d",
                                         want_level, rsp_level));
            end
         end
      end
      levels_pending = level_queue.size();
   end

endmodule

`default_nettype wire

### tb/sv/ordered_bayer_dither_quantizer_tb.sv
// Testbench top for the ordered Bayer dither quantizer: clock, reset, stimulus and verdict.
`default_nettype none

module ordered_bayer_dither_quantizer_tb;
   import obdq_pkg::*;

   localparam int DIRECTED_COUNT = 20;
   localparam int PHASE_COUNT    = 14;
   localparam int PHASE_ITEMS    = 120;
   localparam int HOLD_CYCLES    = 80;

   // {gray, column, row}
   localparam logic [31:0] DIRECTED [DIRECTED_COUNT] = '{
      32'h00_000_000, 32'hFF_FFF_FFF, 32'h00_FFF_000, 32'hFF_000_FFF,
      32'h80_000_000, 32'h7F_001_000, 32'h01_000_001, 32'hFE_001_001,
      32'h40_002_003, 32'hC0_003_002, 32'h00_003_003, 32'hFF_002_002,
      32'h80_AAA_555, 32'h80_555_AAA, 32'h20_001_002, 32'hE0_002_001,
      32'h60_003_001, 32'hA0_001_003, 32'h00_001_001, 32'hFF_003_000
   };

   // {dither_size_log2, levels_log2} per phase, out-of-range values included
   localparam logic [7:0] PHASES [PHASE_COUNT] = '{
      8'h01, 8'h48, 8'h18, 8'h34, 8'h70, 8'h5F, 8'h69,
      8'h22, 8'h43, 8'h08, 8'h36, 8'h45, 8'h17, 8'h21
   };

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [GRAY_W-1:0]     req_gray_in = '0;
   logic [COORD_W-1:0]    req_column  = '0;
   logic [COORD_W-1:0]    req_row     = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic [LEVEL_W-1:0]    rsp_level;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int unsigned fail_count;
   int unsigned levels_pending;

   logic gaps_on      = 1'b1;
   logic stalls_on    = 1'b1;
   logic hold_request = 1'b0;
   int   hold_left    = 0;

   ordered_bayer_dither_quantizer uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_gray_in (req_gray_in),
      .req_column  (req_column),
      .req_row     (req_row),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_level   (rsp_level),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dither_level_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_gray_in    (req_gray_in),
      .req_column     (req_column),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_level      (rsp_level),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .fail_count     (fail_count),
      .levels_pending (levels_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin : level_sink
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_ready    = 1'b0;
         end else begin
            rsp_ready = !(stalls_on && ($urandom_range(0, 99) < 29));
         end
      end
   end

   task automatic send_pixel(input logic [GRAY_W-1:0] gray,
                             input logic [COORD_W-1:0] col,
                             input logic [COORD_W-1:0] row);
      @(negedge clock);
      while (gaps_on && ($urandom_range(0, 99) < 29)) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_gray_in = gray;
      req_column  = col;
      req_row     = row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and let the pipeline empty before touching the registers
   task automatic drain_pixels();
      @(negedge clock);
      req_valid = 1'b0;
      while (levels_pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_access(input reg_index_type idx, input logic wr,
                             input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = wr;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] data;
      logic [GRAY_W-1:0]     gray;
      logic [COORD_W-1:0]    col;
      logic [COORD_W-1:0]    row;
      int                    pick;

      col = '0;
      row = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset configuration: field extremes and low/high sums
      foreach (DIRECTED[i])
         send_pixel(DIRECTED[i][31:24], DIRECTED[i][23:12], DIRECTED[i][11:0]);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain_pixels();
         data = $urandom();
         data[SIZE_W-1:0] = PHASES[p][6:4];
         csr_access(REG_DITHER_SIZE, 1'b1, data);
         data = $urandom();
         data[LEVELS_W-1:0] = PHASES[p][3:0];
         csr_access(REG_LEVELS, 1'b1, data);
         csr_access(REG_DITHER_SIZE, 1'b0, '0);
         csr_access(REG_LEVELS, 1'b0, '0);

         gaps_on   = (p != 2) && (p != 5);
         stalls_on = (p != 5);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 2 && n == 10) hold_request = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               // raster walk, new line now and then
               col = col + COORD_W'(1);
               if ($urandom_range(0, 15) == 0) begin
                  col = '0;
                  row = row + COORD_W'(1);
               end
            end else if (pick < 9) begin
               col = COORD_W'($urandom());
               row = COORD_W'($urandom());
            end else begin
               col = $urandom_range(0, 1) ? '1 : '0;
               row = $urandom_range(0, 1) ? '1 : '0;
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)      gray = '0;
            else if (pick == 1) gray = '1;
            else if (pick == 2) gray = GRAY_W'($urandom_range(124, 132));
            else                gray = GRAY_W'($urandom());
            send_pixel(gray, col, row);
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (levels_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0 && levels_pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
src/obdq_pkg.sv
src/obdq_csr.sv
src/obdq_threshold.sv
src/obdq_quant.sv
src/ordered_bayer_dither_quantizer.sv
tb/sv/dither_level_checker.sv
tb/sv/ordered_bayer_dither_quantizer_tb.sv
